FILE: rtl/core/click_log_stream_parser_unit_assert.svh
// Assertion macros shared by the click-log stream parser modules.
`ifndef CLICK_LOG_STREAM_PARSER_UNIT_ASSERT_SVH
`define CLICK_LOG_STREAM_PARSER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLSP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define CLSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

FILE: rtl/core/clsp_pkg.sv
// Shared types and constants of the click-log stream parser.
package clsp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned RANK_W   = 16;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned SHIFT_W  = 24;
    localparam int unsigned M_DATA_W = 96;

    localparam logic [BYTE_W-1:0] CFG_MASK_RESET = 8'h01;

    // Parser phases, one for each field kind of the stream.
    typedef enum logic [3:0] {
        PH_OPTS   = 4'd0,
        PH_SESSC  = 4'd1,
        PH_DUP    = 4'd2,
        PH_CLICKC = 4'd3,
        PH_RANK   = 4'd4,
        PH_GAP    = 4'd5,
        PH_PLAIN  = 4'd6,
        PH_TOTAL  = 4'd7,
        PH_MDOC   = 4'd8,
        PH_MASS   = 4'd9
    } phase_t;

    // Kinds of decoded records.
    typedef enum logic [KIND_W-1:0] {
        KIND_QUERY      = 3'd0,
        KIND_SESSION    = 3'd1,
        KIND_CLICK      = 3'd2,
        KIND_PLAIN_DOC  = 3'd3,
        KIND_RANK_TOTAL = 3'd4,
        KIND_MASS_DOC   = 3'd5,
        KIND_ZERO_MASS  = 3'd6
    } kind_t;

    // One decoded record.
    typedef struct packed {
        kind_t             kind;
        logic [WORD_W-1:0] query_id;
        logic [WORD_W-1:0] first_value;
        logic [WORD_W-1:0] second_value;
    } record_t;

endpackage

FILE: rtl/core/click_log_stream_parser_unit.sv
// Top level of the click-log stream parser: byte stream in, decoded records out.
//
// Takes one stream byte per transfer on the slave side and emits at most one
// decoded record per byte on the master side; the record of a byte that completes
// a field with a result is registered into the output register, or into the skid
// register behind a stalled record. The parse state is updated by one pass of
// logic per byte, so a byte is taken in every clock while s_tready is high; a
// two-entry output buffer (output register plus skid register) keeps input flowing
// while one record waits, and s_tready drops only when both entries are full.
module click_log_stream_parser_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [clsp_pkg::BYTE_W-1:0]     cfg_wdata,   // concrete_flag_mask
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [clsp_pkg::BYTE_W-1:0]     s_tdata,     // stream_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // query_id [31:0], first_value [63:32], second_value [95:64]
    output logic [clsp_pkg::M_DATA_W-1:0]   m_tdata,
    output logic [clsp_pkg::KIND_W-1:0]     m_tuser      // record_kind
);
    import clsp_pkg::*;

    `include "click_log_stream_parser_unit_assert.svh"

    logic    in_xfer;
    logic    out_xfer;
    logic    dec_valid;
    record_t dec_rec;
    logic    push;
    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    record_t main_reg;
    record_t skid_reg;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = main_valid_reg && m_tready;
    assign push     = in_xfer && dec_valid;

    clsp_decoder u_decoder
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_xfer),
        .in_byte   (s_tdata),
        .rec_valid (dec_valid),
        .rec       (dec_rec)
    );

    // Output buffer occupancy.
    always_comb
    begin
        main_valid_next = skid_valid_reg || push || (main_valid_reg && !out_xfer);
        if (skid_valid_reg)
        begin
            skid_valid_next = !out_xfer;
        end
        else
        begin
            skid_valid_next = push && main_valid_reg && !out_xfer;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Output buffer payload.
    always_ff @(posedge clk)
    begin
        if (out_xfer && skid_valid_reg)
        begin
            main_reg <= skid_reg;
        end
        else if (push && (!main_valid_reg || out_xfer))
        begin
            main_reg <= dec_rec;
        end

        if (push && main_valid_reg && !out_xfer)
        begin
            skid_reg <= dec_rec;
        end
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = main_valid_reg;
    assign m_tuser  = main_reg.kind;
    assign m_tdata  = {main_reg.second_value, main_reg.first_value, main_reg.query_id};

    // The skid entry is only ever filled behind a full output register.
    `CLSP_ASSERT_SAME(a_skid_behind_main, skid_valid_reg, main_valid_reg)
    // A waiting skid entry is not dropped while the output stalls.
    `CLSP_ASSERT_NEXT(a_skid_kept, skid_valid_reg && !m_tready, skid_valid_reg)
    // A record pushed behind a stalled output lands in the skid entry.
    `CLSP_ASSERT_NEXT(a_skid_fill, push && main_valid_reg && !m_tready,
        skid_valid_reg && main_valid_reg)

endmodule

FILE: rtl/core/clsp_decoder.sv
// Parse state and record decode of the click-log stream parser.
module clsp_decoder
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [clsp_pkg::BYTE_W-1:0]    cfg_wdata,
    input  logic                           in_valid,
    input  logic [clsp_pkg::BYTE_W-1:0]    in_byte,
    output logic                           rec_valid,
    output clsp_pkg::record_t              rec
);
    import clsp_pkg::*;

    `include "click_log_stream_parser_unit_assert.svh"

    logic [BYTE_W-1:0]  mask_reg;
    phase_t             phase_reg,     phase_next;
    logic [1:0]         pos_reg,       pos_next;
    logic [SHIFT_W-1:0] shift_reg,     shift_next;
    logic               concrete_reg,  concrete_next;
    logic [WORD_W-1:0]  query_reg,     query_next;
    logic [WORD_W-1:0]  sessions_reg,  sessions_next;
    logic [RANK_W-1:0]  clicks_reg,    clicks_next;
    logic [RANK_W-1:0]  prev_rank_reg, prev_rank_next;
    logic [RANK_W-1:0]  highest_reg,   highest_next;
    logic [RANK_W-1:0]  ranks_reg,     ranks_next;
    logic [WORD_W-1:0]  mass_sum_reg,  mass_sum_next;
    logic [WORD_W-1:0]  target_reg,    target_next;
    logic [WORD_W-1:0]  held_reg,      held_next;

    logic               collecting;
    logic               short_field;
    logic               field_done;
    logic [WORD_W-1:0]  assembled;
    logic [RANK_W-1:0]  gap_rank;
    logic [RANK_W-1:0]  new_rank;
    logic [WORD_W:0]    mass_total;
    logic               do_take_rank;
    logic               do_begin_docs;
    logic               do_next_rank;
    logic               do_end_session;

    // Field assembly: little-endian bytes land at the current byte position.
    always_comb
    begin
        collecting  = (phase_reg != PH_OPTS) && (phase_reg != PH_GAP);
        short_field = (phase_reg == PH_CLICKC) || (phase_reg == PH_RANK);
        field_done  = short_field ? (|pos_reg) : (&pos_reg);
        assembled   = {{(WORD_W-SHIFT_W){1'b0}}, shift_reg}
                    | ({{(WORD_W-BYTE_W){1'b0}}, in_byte} << {pos_reg, 3'b000});
        gap_rank    = prev_rank_reg + {{(RANK_W-BYTE_W){in_byte[BYTE_W-1]}}, in_byte};
        mass_total  = {1'b0, mass_sum_reg} + {1'b0, assembled};
    end

    // Next state and the record of the current byte.
    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        shift_next     = shift_reg;
        concrete_next  = concrete_reg;
        query_next     = query_reg;
        sessions_next  = sessions_reg;
        clicks_next    = clicks_reg;
        prev_rank_next = prev_rank_reg;
        highest_next   = highest_reg;
        ranks_next     = ranks_reg;
        mass_sum_next  = mass_sum_reg;
        target_next    = target_reg;
        held_next      = held_reg;
        do_take_rank   = 1'b0;
        do_begin_docs  = 1'b0;
        do_next_rank   = 1'b0;
        do_end_session = 1'b0;
        new_rank       = gap_rank;
        rec_valid           = 1'b0;
        rec.kind            = KIND_QUERY;
        rec.query_id        = query_reg;
        rec.first_value     = '0;
        rec.second_value    = '0;

        if (in_valid)
        begin
            // Byte position and partial field.
            if (collecting)
            begin
                if (field_done)
                begin
                    pos_next   = '0;
                    shift_next = '0;
                end
                else
                begin
                    pos_next   = pos_reg + 2'd1;
                    shift_next = assembled[SHIFT_W-1:0];
                end
            end

            case (phase_reg)
                PH_OPTS:
                begin
                    concrete_next = |(in_byte & mask_reg);
                    phase_next    = PH_SESSC;
                end
                PH_SESSC:
                begin
                    if (field_done)
                    begin
                        rec_valid       = 1'b1;
                        rec.kind        = KIND_QUERY;
                        rec.first_value = assembled;
                        if (assembled == '0)
                        begin
                            query_next = query_reg + 32'd1;
                        end
                        else
                        begin
                            sessions_next = assembled;
                            phase_next    = PH_DUP;
                        end
                    end
                end
                PH_DUP:
                begin
                    if (field_done)
                    begin
                        held_next  = assembled;
                        phase_next = PH_CLICKC;
                    end
                end
                PH_CLICKC:
                begin
                    if (field_done)
                    begin
                        rec_valid        = 1'b1;
                        rec.kind         = KIND_SESSION;
                        rec.first_value  = held_reg;
                        rec.second_value = {16'h0000, assembled[RANK_W-1:0]};
                        clicks_next      = assembled[RANK_W-1:0];
                        prev_rank_next   = '0;
                        highest_next     = '0;
                        if (assembled[RANK_W-1:0] == '0)
                        begin
                            do_begin_docs = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_RANK;
                        end
                    end
                end
                PH_RANK:
                begin
                    if (field_done)
                    begin
                        new_rank     = assembled[RANK_W-1:0];
                        do_take_rank = 1'b1;
                    end
                end
                PH_GAP:
                begin
                    new_rank     = gap_rank;
                    do_take_rank = 1'b1;
                end
                PH_PLAIN:
                begin
                    if (field_done)
                    begin
                        rec_valid       = 1'b1;
                        rec.kind        = KIND_PLAIN_DOC;
                        rec.first_value = assembled;
                        do_next_rank    = 1'b1;
                    end
                end
                PH_TOTAL:
                begin
                    if (field_done)
                    begin
                        rec_valid       = 1'b1;
                        rec.kind        = KIND_RANK_TOTAL;
                        rec.first_value = assembled;
                        target_next     = assembled;
                        mass_sum_next   = '0;
                        if (assembled == '0)
                        begin
                            do_next_rank = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_MDOC;
                        end
                    end
                end
                PH_MDOC:
                begin
                    if (field_done)
                    begin
                        held_next  = assembled;
                        phase_next = PH_MASS;
                    end
                end
                PH_MASS:
                begin
                    if (field_done)
                    begin
                        rec_valid       = 1'b1;
                        rec.first_value = held_reg;
                        if (assembled == '0)
                        begin
                            rec.kind     = KIND_ZERO_MASS;
                            do_next_rank = 1'b1;
                        end
                        else
                        begin
                            rec.kind         = KIND_MASS_DOC;
                            rec.second_value = assembled;
                            if (mass_total >= {1'b0, target_reg})
                            begin
                                do_next_rank = 1'b1;
                            end
                            else
                            begin
                                mass_sum_next = mass_total[WORD_W-1:0];
                                phase_next    = PH_MDOC;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_OPTS;
                end
            endcase

            // A click rank is reported and folded into the highest rank.
            if (do_take_rank)
            begin
                rec_valid       = 1'b1;
                rec.kind        = KIND_CLICK;
                rec.first_value = {16'h0000, new_rank};
                if (new_rank > highest_reg)
                begin
                    highest_next = new_rank;
                end
                prev_rank_next = new_rank;
                clicks_next    = clicks_reg - 16'd1;
                if (clicks_reg == 16'd1)
                begin
                    do_begin_docs = 1'b1;
                end
                else
                begin
                    phase_next = PH_GAP;
                end
            end

            // Document fields run over ranks one to the highest rank.
            if (do_begin_docs)
            begin
                ranks_next = highest_next;
                if (highest_next == '0)
                begin
                    do_end_session = 1'b1;
                end
                else
                begin
                    phase_next = concrete_reg ? PH_PLAIN : PH_TOTAL;
                end
            end

            if (do_next_rank)
            begin
                ranks_next = ranks_reg - 16'd1;
                if (ranks_reg == 16'd1)
                begin
                    do_end_session = 1'b1;
                end
                else
                begin
                    phase_next = concrete_reg ? PH_PLAIN : PH_TOTAL;
                end
            end

            // The last session of a query moves on to the next query.
            if (do_end_session)
            begin
                sessions_next = sessions_reg - 32'd1;
                if (sessions_reg == 32'd1)
                begin
                    query_next = query_reg + 32'd1;
                    phase_next = PH_SESSC;
                end
                else
                begin
                    phase_next = PH_DUP;
                end
            end
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= CFG_MASK_RESET;
        end
        else if (cfg_we)
        begin
            mask_reg <= cfg_wdata;
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_OPTS;
            pos_reg       <= '0;
            shift_reg     <= '0;
            concrete_reg  <= 1'b0;
            query_reg     <= '0;
            sessions_reg  <= '0;
            clicks_reg    <= '0;
            prev_rank_reg <= '0;
            highest_reg   <= '0;
            ranks_reg     <= '0;
            mass_sum_reg  <= '0;
            target_reg    <= '0;
            held_reg      <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            shift_reg     <= shift_next;
            concrete_reg  <= concrete_next;
            query_reg     <= query_next;
            sessions_reg  <= sessions_next;
            clicks_reg    <= clicks_next;
            prev_rank_reg <= prev_rank_next;
            highest_reg   <= highest_next;
            ranks_reg     <= ranks_next;
            mass_sum_reg  <= mass_sum_next;
            target_reg    <= target_next;
            held_reg      <= held_next;
        end
    end

    // Single-byte phases never leave a partial field behind.
    `CLSP_ASSERT_SAME(a_no_partial_field,
        (phase_reg == PH_OPTS) || (phase_reg == PH_GAP), pos_reg == 2'd0)
    // Document phases follow the mode chosen by the options byte.
    `CLSP_ASSERT_SAME(a_doc_mode,
        (phase_reg == PH_TOTAL) || (phase_reg == PH_MDOC) || (phase_reg == PH_MASS),
        !concrete_reg)
    // Click and document phases always have work left to count down.
    `CLSP_ASSERT_SAME(a_counts_live,
        (phase_reg == PH_RANK) || (phase_reg == PH_GAP) || (phase_reg == PH_PLAIN)
        || (phase_reg == PH_TOTAL),
        ((clicks_reg != '0) || (phase_reg == PH_PLAIN) || (phase_reg == PH_TOTAL))
        && (sessions_reg != '0))

endmodule

FILE: tb/sv/tb_click_log_stream_parser_unit.sv
// Self-checking testbench for the click-log stream parser: byte stream in, records checked out.
`timescale 1ns / 100ps

module tb_click_log_stream_parser_unit;

    import clsp_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [BYTE_W-1:0]     cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata;     // stream_byte
    logic                  m_tvalid;
    logic                  m_tready;
    // query_id [31:0], first_value [63:32], second_value [95:64]
    logic [M_DATA_W-1:0]   m_tdata;
    logic [KIND_W-1:0]     m_tuser;     // record_kind

    // Shadow of the parser state, advanced once per accepted byte.
    logic [7:0]  mask_shadow;
    phase_t      cur_phase;
    logic [1:0]  byte_pos;
    logic [31:0] shift_acc;
    bit          plain_mode;
    logic [31:0] query_num;
    logic [31:0] sessions_rem;
    logic [15:0] clicks_rem;
    logic [15:0] last_rank;
    logic [15:0] top_rank;
    logic [15:0] ranks_rem;
    logic [31:0] mass_acc;
    logic [31:0] mass_goal;
    logic [31:0] held_value;

    // Records the parser owes us, oldest first.
    record_t     expected_records[$];

    int unsigned mismatch_count = 0;
    int unsigned records_seen = 0;
    int unsigned bytes_accepted = 0;
    int unsigned pairs_in_rank = 0;
    int          send_style = 1;
    int          recv_style = 1;
    bit          hold_request = 1'b0;
    int unsigned hold_cycles = 0;

    click_log_stream_parser_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Free-running 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch at record %0d: got %h, expected %h",
                 $time, what, records_seen, got, want);
        mismatch_count++;
    endtask

    // Draws the number of idle cycles before the next transfer for a given idling style.
    function automatic int unsigned idle_cycles(input int style);
        if (style == 0)
            return 0;
        if (style == 1)
            return $urandom_range(0, 15);
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
    endfunction

    // Queues one expected record tagged with the current query number.
    function automatic void note_record(input kind_t kind, input logic [31:0] first,
                                        input logic [31:0] second);
        record_t rec;
        rec.kind         = kind;
        rec.query_id     = query_num;
        rec.first_value  = first;
        rec.second_value = second;
        expected_records.push_back(rec);
    endfunction

    // Shifts one byte into a little-endian field; returns 1 when the field is complete.
    function automatic bit gather(input logic [7:0] b, input int unsigned len,
                                  output logic [31:0] value);
        shift_acc = shift_acc | (32'(b) << (8 * byte_pos));
        value = shift_acc;
        if (byte_pos + 1 >= len)
        begin
            shift_acc = '0;
            byte_pos  = '0;
            return 1'b1;
        end
        byte_pos = byte_pos + 2'd1;
        return 1'b0;
    endfunction

    // A session is done: either the next session or the next query follows.
    function automatic void finish_session();
        sessions_rem = sessions_rem - 32'd1;
        if (sessions_rem == 0)
        begin
            query_num = query_num + 32'd1;
            cur_phase = PH_SESSC;
        end
        else
            cur_phase = PH_DUP;
    endfunction

    // Document fields of a rank: plain id list or a mass group.
    function automatic void enter_rank();
        cur_phase = plain_mode ? PH_PLAIN : PH_TOTAL;
    endfunction

    function automatic void start_documents();
        ranks_rem = top_rank;
        if (ranks_rem == 0)
            finish_session();
        else
            enter_rank();
    endfunction

    function automatic void advance_rank();
        ranks_rem = ranks_rem - 16'd1;
        if (ranks_rem == 0)
            finish_session();
        else
            enter_rank();
    endfunction

    // Bookkeeping for one click, absolute or gap-coded.
    function automatic void record_rank(input logic [15:0] r);
        if (r > top_rank)
            top_rank = r;
        last_rank  = r;
        clicks_rem = clicks_rem - 16'd1;
        if (clicks_rem == 0)
            start_documents();
        else
            cur_phase = PH_GAP;
    endfunction

    // Advances the shadow parser by one byte and queues the record it produces, if any.
    function automatic void decode_byte(input logic [7:0] b);
        logic [31:0] v;
        logic [15:0] r;
        logic [32:0] total;
        case (cur_phase)
            PH_OPTS:
            begin
                plain_mode = (b & mask_shadow) != 8'h00;
                cur_phase  = PH_SESSC;
            end
            PH_SESSC:
            begin
                if (gather(b, 4, v))
                begin
                    note_record(KIND_QUERY, v, '0);
                    if (v == 0)
                        query_num = query_num + 32'd1;
                    else
                    begin
                        sessions_rem = v;
                        cur_phase    = PH_DUP;
                    end
                end
            end
            PH_DUP:
            begin
                if (gather(b, 4, v))
                begin
                    held_value = v;
                    cur_phase  = PH_CLICKC;
                end
            end
            PH_CLICKC:
            begin
                if (gather(b, 2, v))
                begin
                    note_record(KIND_SESSION, held_value, {16'h0000, v[15:0]});
                    clicks_rem = v[15:0];
                    last_rank  = '0;
                    top_rank   = '0;
                    if (clicks_rem == 0)
                        start_documents();
                    else
                        cur_phase = PH_RANK;
                end
            end
            PH_RANK:
            begin
                if (gather(b, 2, v))
                begin
                    note_record(KIND_CLICK, {16'h0000, v[15:0]}, '0);
                    record_rank(v[15:0]);
                end
            end
            PH_GAP:
            begin
                // Signed 8-bit gap from the previous rank, wrapping at 16 bits.
                r = last_rank + {{8{b[7]}}, b};
                note_record(KIND_CLICK, {16'h0000, r}, '0);
                record_rank(r);
            end
            PH_PLAIN:
            begin
                if (gather(b, 4, v))
                begin
                    note_record(KIND_PLAIN_DOC, v, '0);
                    advance_rank();
                end
            end
            PH_TOTAL:
            begin
                if (gather(b, 4, v))
                begin
                    note_record(KIND_RANK_TOTAL, v, '0);
                    mass_goal = v;
                    mass_acc  = '0;
                    if (v == 0)
                        advance_rank();
                    else
                        cur_phase = PH_MDOC;
                end
            end
            PH_MDOC:
            begin
                if (gather(b, 4, v))
                begin
                    held_value = v;
                    cur_phase  = PH_MASS;
                end
            end
            PH_MASS:
            begin
                if (gather(b, 4, v))
                begin
                    if (v == 0)
                    begin
                        // A zero mass would never reach the total, so the rank is dropped.
                        note_record(KIND_ZERO_MASS, held_value, '0);
                        advance_rank();
                    end
                    else
                    begin
                        // Compare at 33 bits so a sum past 2^32 still reaches the total.
                        total = {1'b0, mass_acc} + {1'b0, v};
                        note_record(KIND_MASS_DOC, held_value, v);
                        if (total >= {1'b0, mass_goal})
                            advance_rank();
                        else
                        begin
                            mass_acc  = total[31:0];
                            cur_phase = PH_MDOC;
                        end
                    end
                end
            end
            default:
            begin
                cur_phase = PH_OPTS;
            end
        endcase
    endfunction

    // Writes the flag mask register with a one-cycle enable pulse.
    task automatic write_mask(input logic [7:0] value);
        cfg_we      <= 1'b1;
        cfg_wdata   <= value;
        mask_shadow = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one byte after a random idle gap and waits for its transfer.
    task automatic send_byte(input logic [7:0] value);
        int unsigned idle;
        idle = idle_cycles(send_style);
        if (idle != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        decode_byte(value);
        bytes_accepted++;
    endtask

    // Sends a little-endian field of the given byte count.
    task automatic send_field(input logic [31:0] value, input int unsigned width);
        int unsigned i;
        for (i = 0; i < width; i++)
            send_byte(value[8*i +: 8]);
    endtask

    // Picks and sends a well-formed field for whatever the parser expects next.
    task automatic send_next_field();
        logic [31:0] value;
        logic [31:0] remaining;
        case (cur_phase)
            PH_SESSC:
            begin
                value = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 3);
                send_field(value, 4);
            end
            PH_DUP, PH_PLAIN, PH_MDOC:
            begin
                send_field($urandom(), 4);
            end
            PH_CLICKC:
            begin
                value = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom_range(1, 4);
                send_field(value, 2);
            end
            PH_RANK:
            begin
                send_field($urandom_range(0, 6), 2);
            end
            PH_GAP:
            begin
                // Aim at a small rank so the document section stays short.
                value = 32'($urandom_range(0, 8)) - {16'h0000, last_rank};
                send_field(value, 1);
            end
            PH_TOTAL:
            begin
                pairs_in_rank = 0;
                case ($urandom_range(0, 7))
                    0:       value = 32'd0;
                    1:       value = $urandom();
                    default: value = $urandom_range(1, 1000);
                endcase
                send_field(value, 4);
            end
            PH_MASS:
            begin
                remaining = mass_goal - mass_acc;
                pairs_in_rank++;
                if ($urandom_range(0, 9) == 0)
                    value = 32'd0;
                else if (pairs_in_rank >= 3)
                    value = remaining;
                else if ($urandom_range(0, 3) == 0)
                    value = $urandom();
                else
                    value = $urandom_range(1, remaining);
                send_field(value, 4);
            end
            default:
            begin
                send_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Stops offering bytes and waits until every expected record has been seen, reporting any that never come.
    task automatic wait_for_drain();
        int unsigned waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (expected_records.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_records.size() != 0)
        begin
            report_mismatch("records never produced, count", expected_records.size(), 32'd0);
            expected_records.delete();
        end
        repeat (8) @(posedge clk);
    endtask

    // Mask extremes, then the options byte that fixes plain or mass-group mode.
    task automatic test_options_and_mask();
        logic [7:0] mask;
        logic [7:0] opts;
        write_mask(8'h00);
        write_mask(8'hFF);
        case ($urandom_range(0, 3))
            0:       mask = 8'h00;
            1:       mask = 8'h01;
            2:       mask = 8'hFF;
            default: mask = 8'($urandom_range(1, 254));
        endcase
        write_mask(mask);
        // A zero mask always means mass groups; otherwise either mode is picked at random.
        if (mask != 8'h00 && $urandom_range(0, 1) == 1)
            opts = 8'($urandom_range(0, 255)) | (mask & (~mask + 8'd1));
        else
            opts = 8'($urandom_range(0, 255)) & ~mask;
        send_byte(opts);
    endtask

    // Hand-built queries covering the corner cases of each field kind.
    task automatic test_directed_fields();
        send_style = 1;
        // An empty query closes at once.
        send_field(32'd0, 4);
        // Two sessions: the first has no clicks, the second clicks ranks 2, 1 and 3.
        send_field(32'd2, 4);
        send_field(32'hFFFF_FFFF, 4);
        send_field(32'd0, 2);
        send_field(32'd0, 4);
        send_field(32'd3, 2);
        send_field(32'd2, 2);
        send_field(32'h0000_00FF, 1);
        send_field(32'h0000_0002, 1);
        if (plain_mode)
        begin
            send_field(32'd0, 4);
            send_field(32'hFFFF_FFFF, 4);
            send_field($urandom(), 4);
        end
        else
        begin
            // Zero total, then a total reached only through a sum of 2^32, then a zero mass.
            send_field(32'd0, 4);
            send_field(32'hFFFF_FFFF, 4);
            send_field(32'hFFFF_FFFF, 4);
            send_field(32'h8000_0000, 4);
            send_field(32'h0000_0001, 4);
            send_field(32'h8000_0000, 4);
            send_field(32'd5, 4);
            send_field(32'h5A5A_5A5A, 4);
            send_field(32'd0, 4);
        end
        wait_for_drain();
    endtask

    // Well-formed random queries in three rounds, with a mask write after each round.
    task automatic test_random_stream();
        int unsigned start;
        int round;
        for (round = 0; round < 3; round++)
        begin
            start = bytes_accepted;
            while (bytes_accepted - start < 380)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_style = int'($urandom_range(0, 2));
                send_next_field();
            end
            wait_for_drain();
            case (round)
                0:       write_mask(8'h00);
                1:       write_mask(8'hFF);
                default: write_mask(8'($urandom_range(1, 254)));
            endcase
        end
    endtask

    // The sink holds off while bytes keep coming, so the output buffer fills and
    // the input stalls; afterwards the source pauses until everything is out.
    task automatic test_output_hold_off();
        int unsigned start;
        start = bytes_accepted;
        send_style   = 0;
        hold_cycles  = 200;
        hold_request = 1'b1;
        while (bytes_accepted - start < 80)
            send_next_field();
        wait_for_drain();
        write_mask(8'($urandom_range(1, 254)));
    endtask

    // Largest counts and ranks, then raw bytes that all land as click gaps.
    task automatic test_extreme_counts();
        int i;
        send_style = 2;
        while (cur_phase != PH_SESSC)
            send_next_field();
        send_field(32'hFFFF_FFFF, 4);
        send_field($urandom(), 4);
        send_field(32'h0000_FFFF, 2);
        send_field(32'h0000_FFFF, 2);
        send_field(32'h0000_0080, 1);
        send_field(32'h0000_007F, 1);
        for (i = 0; i < 60; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // Result sink: random pauses per transfer, plus a long hold-off on request.
    initial
    begin : record_sink
        int unsigned pause;
        int unsigned transfers;
        m_tready  = 1'b0;
        transfers = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_request = 1'b0;
            end
            if (transfers % 40 == 0)
                recv_style = int'($urandom_range(0, 2));
            pause = idle_cycles(recv_style);
            if (pause != 0)
            begin
                m_tready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_tvalid !== 1'b1);
            transfers++;
        end
    end

    // Compares every output transfer with the oldest expected record.
    always @(posedge clk)
    begin : record_check
        record_t want;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            records_seen++;
            if (expected_records.size() == 0)
                report_mismatch("unexpected record, kind", {29'd0, m_tuser}, 32'd0);
            else
            begin
                want = expected_records.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("record kind", {29'd0, m_tuser}, {29'd0, want.kind});
                if (m_tdata[31:0] !== want.query_id)
                    report_mismatch("query id", m_tdata[31:0], want.query_id);
                if (m_tdata[63:32] !== want.first_value)
                    report_mismatch("first value", m_tdata[63:32], want.first_value);
                if (m_tdata[95:64] !== want.second_value)
                    report_mismatch("second value", m_tdata[95:64], want.second_value);
            end
        end
    end

    // Run limit.
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Reset, the tests in turn, then the verdict.
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;

        mask_shadow  = CFG_MASK_RESET;
        cur_phase    = PH_OPTS;
        byte_pos     = '0;
        shift_acc    = '0;
        plain_mode   = 1'b0;
        query_num    = '0;
        sessions_rem = '0;
        clicks_rem   = '0;
        last_rank    = '0;
        top_rank     = '0;
        ranks_rem    = '0;
        mass_acc     = '0;
        mass_goal    = '0;
        held_value   = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_options_and_mask();
        test_directed_fields();
        test_random_stream();
        test_output_hold_off();
        test_extreme_counts();
        wait_for_drain();

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/clsp_pkg.sv
rtl/core/clsp_decoder.sv
rtl/core/click_log_stream_parser_unit.sv
tb/sv/tb_click_log_stream_parser_unit.sv
